// ===== hdl/tcw_pkg.sv =====
// shared types, codes and constants of the text console writer
`default_nettype none

package tcw_pkg;

    localparam int ROWS_DEF        = 25;
    localparam int COLS_DEF        = 80;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0]  ATTR_RESET = 8'h07;
    localparam logic [15:0] BLANK_CELL = 16'h0720;

    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_BEL = 8'd7;
    localparam logic [7:0] CH_FF  = 8'd12;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  char_code;
        logic [10:0] read_index;
    } t_in_beat;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic        bell;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } t_out_beat;

    typedef enum logic [2:0] {
        OP_READ,
        OP_CR,
        OP_LF,
        OP_BS,
        OP_BEL,
        OP_FF,
        OP_PRINT
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  char_code;
        logic [10:0] read_index;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_SCROLL_END,
        ST_CLEAR
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/tcw_front.sv =====
// input stage: accepts beats and classifies them into console operations
`default_nettype none

module tcw_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire tcw_pkg::t_in_beat i_in_data,
    output logic                  o_cmd_valid,
    input  wire logic             i_cmd_ready,
    output tcw_pkg::t_cmd         o_cmd
);
    import tcw_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    always_comb begin
        n_cmd.char_code  = i_in_data.char_code;
        n_cmd.read_index = i_in_data.read_index;
        if (i_in_data.command == CMD_READ) begin
            n_cmd.op = OP_READ;
        end else begin
            case (i_in_data.char_code)
                CH_CR:   n_cmd.op = OP_CR;
                CH_LF:   n_cmd.op = OP_LF;
                CH_BS:   n_cmd.op = OP_BS;
                CH_BEL:  n_cmd.op = OP_BEL;
                CH_FF:   n_cmd.op = OP_FF;
                default: n_cmd.op = OP_PRINT;
            endcase
        end
    end

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tcw_fifo.sv =====
// short command queue between the front and the back
`default_nettype none

module tcw_fifo #(
    parameter int DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    input  wire tcw_pkg::t_cmd    i_push_data,
    output logic                  o_pop_valid,
    input  wire logic             i_pop_ready,
    output tcw_pkg::t_cmd         o_pop_data
);
    import tcw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tcw_back.sv =====
// execution side: screen memory, cursor, scroll and clear sweeps, result register
`default_nettype none

module tcw_back #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [7:0]       i_cfg_data,
    input  wire logic             i_cmd_valid,
    output logic                  o_cmd_ready,
    input  wire tcw_pkg::t_cmd    i_cmd,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output tcw_pkg::t_out_beat    o_out_data
);
    import tcw_pkg::*;

    localparam int CELLS       = ROWS * COLS;
    localparam int BLANK_START = (ROWS - 1) * COLS;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int COL_W       = $clog2(COLS);
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int POS_W       = (ADDR_W > 11) ? ADDR_W : 11;

    logic [15:0]       r_mem [CELLS];
    logic [15:0]       r_rdata;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [7:0]        r_attr;
    logic              r_wr_vld, n_wr_vld;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic              r_wr_blank, n_wr_blank;
    logic              r_rd_ok, n_rd_ok;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic              pop;
    logic              row_last;
    logic              col_last;
    logic              ptr_last;
    logic              wraps;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic              out_load;
    t_out_beat         n_out;
    logic [POS_W-1:0]  cur_pos;
    logic [POS_W-1:0]  new_pos;
    logic [POS_W-1:0]  idx_ext;

    assign pop      = (r_state == ST_IDLE) && i_cmd_valid && (!r_out_valid || i_out_ready);
    assign row_last = (r_row == ROW_W'(ROWS - 1));
    assign col_last = (r_col == COL_W'(COLS - 1));
    assign ptr_last = (r_ptr == ADDR_W'(CELLS - 1));
    assign wraps    = (i_cmd.op == OP_LF) || ((i_cmd.op == OP_PRINT) && col_last);
    assign cur_pos  = POS_W'(r_row) * POS_W'(COLS) + POS_W'(r_col);
    assign new_pos  = POS_W'(n_row) * POS_W'(COLS) + POS_W'(n_col);
    assign idx_ext  = POS_W'(i_cmd.read_index);

    assign o_cmd_ready = pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        case (r_state)
            ST_INIT: begin
                n_ptr = r_ptr + ADDR_W'(1);
                if (ptr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pop) begin
                    if (i_cmd.op == OP_READ) begin
                        n_state = ST_READ;
                    end else if (i_cmd.op == OP_FF) begin
                        n_state = ST_CLEAR;
                        n_ptr   = '0;
                    end else if (wraps && row_last) begin
                        n_state = ST_SCROLL;
                        n_ptr   = ADDR_W'(COLS);
                    end
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            ST_SCROLL: begin
                n_ptr = r_ptr + ADDR_W'(1);
                if (ptr_last) begin
                    n_state = ST_SCROLL_END;
                end
            end
            ST_SCROLL_END: begin
                n_state = ST_IDLE;
            end
            ST_CLEAR: begin
                n_ptr = r_ptr + ADDR_W'(1);
                if (ptr_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
                n_ptr   = '0;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        mem_we     = 1'b0;
        mem_waddr  = r_ptr;
        mem_wdata  = BLANK_CELL;
        mem_raddr  = '0;
        n_wr_vld   = 1'b0;
        n_wr_addr  = r_ptr;
        n_wr_blank = 1'b1;
        n_rd_ok    = r_rd_ok;
        out_load   = 1'b0;
        n_out.bell      = 1'b0;
        n_out.cell_char = 8'h00;
        n_out.cell_attr = 8'h00;
        case (r_state)
            ST_INIT: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                if (pop) begin
                    case (i_cmd.op)
                        OP_READ: begin
                            mem_raddr = idx_ext[ADDR_W-1:0];
                            n_rd_ok   = (32'(i_cmd.read_index) < CELLS);
                        end
                        OP_CR: begin
                            n_col    = '0;
                            out_load = 1'b1;
                        end
                        OP_LF: begin
                            n_col = '0;
                            if (!row_last) begin
                                n_row    = r_row + ROW_W'(1);
                                out_load = 1'b1;
                            end
                        end
                        OP_BS: begin
                            if (r_col != '0) begin
                                n_col = r_col - COL_W'(1);
                            end
                            out_load = 1'b1;
                        end
                        OP_BEL: begin
                            n_out.bell = 1'b1;
                            out_load   = 1'b1;
                        end
                        OP_FF: begin
                            n_row = ROW_W'(1);
                            n_col = '0;
                        end
                        OP_PRINT: begin
                            mem_we    = 1'b1;
                            mem_waddr = cur_pos[ADDR_W-1:0];
                            mem_wdata = {r_attr, i_cmd.char_code};
                            if (col_last) begin
                                n_col = '0;
                                if (!row_last) begin
                                    n_row    = r_row + ROW_W'(1);
                                    out_load = 1'b1;
                                end
                            end else begin
                                n_col    = r_col + COL_W'(1);
                                out_load = 1'b1;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                out_load = 1'b1;
                if (r_rd_ok) begin
                    n_out.cell_char = r_rdata[7:0];
                    n_out.cell_attr = r_rdata[15:8];
                end
            end
            ST_SCROLL: begin
                // read one row ahead, write the beat read last cycle
                if (r_ptr < ADDR_W'(BLANK_START)) begin
                    mem_raddr = r_ptr + ADDR_W'(COLS);
                end
                n_wr_vld   = 1'b1;
                n_wr_addr  = r_ptr;
                n_wr_blank = (r_ptr >= ADDR_W'(BLANK_START));
                mem_we     = r_wr_vld;
                mem_waddr  = r_wr_addr;
                mem_wdata  = r_wr_blank ? BLANK_CELL : r_rdata;
            end
            ST_SCROLL_END: begin
                mem_we    = r_wr_vld;
                mem_waddr = r_wr_addr;
                mem_wdata = r_wr_blank ? BLANK_CELL : r_rdata;
                out_load  = 1'b1;
            end
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (ptr_last) begin
                    out_load = 1'b1;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
        n_out.cursor_pos = new_pos[10:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_ptr       <= '0;
            r_row       <= ROW_W'(1);
            r_col       <= '0;
            r_attr      <= ATTR_RESET;
            r_wr_vld    <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_row    <= n_row;
            r_col    <= n_col;
            r_wr_vld <= n_wr_vld;
            r_rd_ok  <= n_rd_ok;
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr  <= n_wr_addr;
        r_wr_blank <= n_wr_blank;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    a_busy_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !r_out_valid)
        else $error("result pending while a long operation runs");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row != '0) && (r_row <= ROW_W'(ROWS - 1)))
        else $error("cursor row outside the scrolling area");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(COLS - 1))
        else $error("cursor column past the last column");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCROLL) |-> row_last)
        else $error("scroll running with cursor off the bottom row");

endmodule

`default_nettype wire

// ===== hdl/text_console_writer.sv =====
// top level of the text console writer: front, command queue and back
//
//  channel   direction  handshake               payload
//  cfg       in         i_cfg_we                i_cfg_data (char_attr)
//  in        in         i_in_valid/o_in_ready   i_in_data  (t_in_beat)
//  out       out        o_out_valid/i_out_ready o_out_data (t_out_beat)
//
// printable, CR, BS and BEL beats are executed straight from idle; reads also pass through a memory read state
// LF or wrap on the bottom row sweeps the store below the top row, moving rows up and blanking the last
// FF sweeps every cell
// after reset a clearing pass over every cell runs before the first beat is executed
// the front and queue keep taking beats while the back is busy or the result is stalled, until the queue is full
`default_nettype none

module text_console_writer #(
    parameter int ROWS        = tcw_pkg::ROWS_DEF,
    parameter int COLS        = tcw_pkg::COLS_DEF,
    parameter int QUEUE_DEPTH = tcw_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [7:0]       i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire tcw_pkg::t_in_beat i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output tcw_pkg::t_out_beat    o_out_data
);
    import tcw_pkg::*;

    logic front_valid;
    logic front_ready;
    t_cmd front_cmd;
    logic queue_valid;
    logic queue_ready;
    t_cmd queue_cmd;

    tcw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    tcw_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_cmd),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_data   (queue_cmd)
    );

    tcw_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .i_cmd       (queue_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== test/tcw_screen_checker.sv =====
`timescale 1ns / 100ps
// screen mirror of the text console writer: predicts each result beat and compares it
module tcw_screen_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [7:0]    i_cfg_data,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_ready,
    input  tcw_pkg::t_in_beat  i_in_data,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_ready,
    input  tcw_pkg::t_out_beat i_out_data,
    output int                 o_fail_count,
    output int                 o_waiting,
    output int                 o_checked,
    output int                 o_scrolls,
    output int                 o_clears
);
    import tcw_pkg::*;

    localparam int ROWS  = ROWS_DEF;
    localparam int COLS  = COLS_DEF;
    localparam int CELLS = ROWS * COLS;

    logic [15:0] screen_cells [CELLS];
    int          cur_row;
    int          cur_col;
    logic [7:0]  char_attr;
    t_out_beat   console_outcomes [$];
    int          fails   = 0;
    int          checked = 0;
    int          scrolls = 0;
    int          clears  = 0;

    task automatic blank_screen();
        for (int i = 0; i < CELLS; i++) screen_cells[i] = BLANK_CELL;
        cur_row = 1;
        cur_col = 0;
    endtask

    task automatic feed_line();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
            // top line stays, rows below it move up one
            for (int i = COLS; i < (ROWS - 1) * COLS; i++) screen_cells[i] = screen_cells[i + COLS];
            for (int i = (ROWS - 1) * COLS; i < CELLS; i++) screen_cells[i] = BLANK_CELL;
            cur_row = ROWS - 1;
            scrolls++;
        end
    endtask

    task automatic run_console_beat(input t_in_beat b, output t_out_beat r);
        int pos;
        r = '0;
        if (b.command == CMD_READ) begin
            if (b.read_index < CELLS) begin
                r.cell_char = screen_cells[b.read_index][7:0];
                r.cell_attr = screen_cells[b.read_index][15:8];
            end
        end else begin
            case (b.char_code)
                CH_CR: cur_col = 0;
                CH_LF: feed_line();
                CH_BS: if (cur_col > 0) cur_col--;
                CH_BEL: r.bell = 1'b1;
                CH_FF: begin
                    blank_screen();
                    clears++;
                end
                default: begin
                    pos = cur_row * COLS + cur_col;
                    if (pos < CELLS) screen_cells[pos] = {char_attr, b.char_code};
                    cur_col++;
                    if (cur_col >= COLS) feed_line();
                end
            endcase
        end
        r.cursor_pos = 11'(cur_row * COLS + cur_col);
    endtask

    task automatic check_result(input t_out_beat got);
        t_out_beat want;
        logic      bad;
        bad = 1'b0;
        if (console_outcomes.size() == 0) begin
            fails++;
            $error("result beat with nothing pending: cursor_pos %0d", got.cursor_pos);
        end else begin
            want = console_outcomes.pop_front();
            checked++;
            if (got.cursor_pos !== want.cursor_pos) begin
                bad = 1'b1;
                $error("cursor_pos: expected %0d, actual %0d", want.cursor_pos, got.cursor_pos);
            end
            if (got.bell !== want.bell) begin
                bad = 1'b1;
                $error("bell: expected %0d, actual %0d", want.bell, got.bell);
            end
            if (got.cell_char !== want.cell_char) begin
                bad = 1'b1;
                $error("cell_char: expected 0x%02h, actual 0x%02h", want.cell_char,
                       got.cell_char);
            end
            if (got.cell_attr !== want.cell_attr) begin
                bad = 1'b1;
                $error("cell_attr: expected 0x%02h, actual 0x%02h", want.cell_attr,
                       got.cell_attr);
            end
            if (bad) fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_beat r;
        if (!i_rst_n) begin
            blank_screen();
            char_attr = ATTR_RESET;
            console_outcomes.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            if (i_in_valid && i_in_ready) begin
                run_console_beat(i_in_data, r);
                console_outcomes.push_back(r);
            end
            if (i_cfg_we) char_attr = i_cfg_data;
        end
        o_fail_count <= fails;
        o_waiting    <= console_outcomes.size();
        o_checked    <= checked;
        o_scrolls    <= scrolls;
        o_clears     <= clears;
    end

endmodule

// ===== test/tb_text_console_writer.sv =====
`timescale 1ns / 100ps
// testbench top of the text console writer: stimulus, handshake idling and verdict
module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int CELLS      = ROWS_DEF * COLS_DEF;
    localparam int IDLE_LIMIT = 20000;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       cfg_we   = 1'b0;
    logic [7:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    t_in_beat   in_beat  = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_beat  out_beat;

    logic sender_steady = 1'b0;
    logic sink_steady   = 1'b0;
    int   sink_hold     = 0;
    int   idle_cycles   = 0;
    int   beats_sent    = 0;
    int   reads_sent    = 0;
    int   attr_writes   = 0;

    int fail_count;
    int waiting;
    int checked;
    int scrolls;
    int clears;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    text_console_writer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat)
    );

    tcw_screen_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_beat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_beat),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_checked    (checked),
        .o_scrolls    (scrolls),
        .o_clears     (clears)
    );

    // result side stalls a random number of cycles after every beat, unless sink_steady is set
    always @(posedge clk) begin : sink
        int n;
        if (!rst_n) begin
            out_ready <= 1'b0;
            sink_hold <= 0;
        end else if (out_valid && out_ready) begin
            n = sink_steady ? 0 : $urandom_range(0, 19);
            sink_hold <= n;
            out_ready <= (n == 0);
        end else if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            out_ready <= (sink_hold == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(input t_in_beat b);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
        if (b.command == CMD_READ) reads_sent++;
    endtask

    task automatic put_char(input logic [7:0] c);
        t_in_beat b;
        b.command    = CMD_WRITE;
        b.char_code  = c;
        b.read_index = 11'($urandom_range(0, 2047));
        send_beat(b);
    endtask

    task automatic peek_cell(input int idx);
        t_in_beat b;
        b.command    = CMD_READ;
        b.char_code  = 8'($urandom_range(0, 255));
        b.read_index = 11'(idx);
        send_beat(b);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c inside {CH_CR, CH_LF, CH_BS, CH_BEL, CH_FF}) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // drain every pending result, then change the attribute
    task automatic settle_and_set_attr(input logic [7:0] a);
        in_valid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
        cfg_we   <= 1'b1;
        cfg_data <= a;
        @(posedge clk);
        cfg_we <= 1'b0;
        attr_writes++;
    endtask

    task automatic random_phase(input int count);
        int stop;
        int roll;
        int n;
        stop = beats_sent + count;
        while (beats_sent < stop) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                // a line of text, now and then one long enough to wrap
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 12);
                repeat (n) put_char(text_byte());
                roll = $urandom_range(0, 19);
                if (roll < 14) put_char(CH_LF);
                else if (roll < 17) put_char(CH_CR);
            end else if (roll < 55) begin
                repeat ($urandom_range(1, 30)) put_char(CH_LF);
            end else if (roll < 63) begin
                case ($urandom_range(0, 2))
                    0: repeat ($urandom_range(1, 4)) put_char(CH_BS);
                    1: put_char(CH_CR);
                    default: put_char(CH_BEL);
                endcase
            end else if (roll < 93) begin
                repeat ($urandom_range(1, 6)) begin
                    roll = $urandom_range(0, 9);
                    if (roll < 7) peek_cell($urandom_range(0, CELLS - 1));
                    else if (roll < 9) peek_cell($urandom_range((ROWS_DEF - 2) * COLS_DEF, CELLS - 1));
                    else peek_cell($urandom_range(0, 2047));
                end
            end else if (roll < 95) begin
                put_char(CH_FF);
            end else begin
                send_beat(t_in_beat'(20'($urandom)));
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] attr_plan [5];
        attr_plan[0] = 8'h00;
        attr_plan[1] = 8'hFF;
        attr_plan[2] = 8'($urandom);
        attr_plan[3] = 8'($urandom);
        attr_plan[4] = 8'h80;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed beats under the reset attribute
        peek_cell(0);
        peek_cell(CELLS - 1);
        peek_cell(CELLS);
        peek_cell(2047);
        put_char(CH_BS);
        put_char(8'h00);
        put_char(8'hFF);
        put_char("A");
        put_char(CH_BS);
        put_char(8'h7F);
        put_char(CH_BEL);
        put_char(CH_CR);
        put_char(CH_LF);
        put_char("x");
        peek_cell(COLS_DEF);
        peek_cell(COLS_DEF + 1);
        peek_cell(2 * COLS_DEF);
        peek_cell(2 * COLS_DEF + 1);
        put_char(CH_FF);
        peek_cell(COLS_DEF);
        send_beat('{command: CMD_WRITE, char_code: 8'h5A, read_index: 11'h7FF});
        send_beat('{command: CMD_READ, char_code: 8'hFF, read_index: 11'h000});

        for (int p = 0; p < 5; p++) begin
            sender_steady = (p == 1 || p == 3);
            sink_steady  <= (p == 1);
            settle_and_set_attr(attr_plan[p]);
            random_phase(165);
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
        repeat (CELLS + 100) @(posedge clk);

        $display("run summary: %0d beats sent (%0d cell reads), %0d attribute writes",
                 beats_sent, reads_sent, attr_writes);
        $display("%0d results compared, %0d scrolls and %0d screen clears mirrored",
                 checked, scrolls, clears);
        if (fail_count == 0 && waiting == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
